>>> rtl/assert_macros.svh
// Assertion helpers shared by the lexer modules.
// Each module that uses them has aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset
`define SQLX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next
`define SQLX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sqlx_pkg.sv
package sqlx_pkg;

    // Defaults for top-level parameters
    localparam int POS_WIDTH_DEF     = 32;
    localparam int KEYWORD_CHARS_DEF = 6;

    // Output field widths
    localparam int OUT_W      = 32;
    localparam int KIND_W     = 5;

    // Keyword table geometry
    localparam int KW_MAX_LEN   = 6;
    localparam int KW_LEN_W     = 3;
    localparam int NUM_KEYWORDS = 15;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd1;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd3;
    localparam logic [KIND_W-1:0] KIND_EQUAL    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_STRING   = 5'd5;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd8;
    localparam logic [KIND_W-1:0] KIND_EOF      = 5'd23;

    // Character codes
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Input opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Keyword spellings, first character in the top byte, zero padded
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        "SELECT", "INSERT", "UPDATE", "DELETE", "CREATE",
        {"DROP", 16'h0}, {"TABLE", 8'h0}, {"FROM", 16'h0}, {"WHERE", 8'h0},
        {"INTO", 16'h0}, "VALUES", {"SET", 24'h0}, {"AND", 24'h0},
        {"OR", 32'h0}, {"NOT", 24'h0}
    };
    localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd6,
        3'd3, 3'd3, 3'd2, 3'd3
    };

    // One token on its way from front to back
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [OUT_W-1:0]        start;
        logic [OUT_W-1:0]        len;
        logic                    last;
        logic                    kw_short;   // length fits a keyword
        logic [KW_LEN_W-1:0]     kw_len;
        logic [8*KW_MAX_LEN-1:0] kw_chars;
    } tok_t;

    // Up to two tokens written per transfer, compacted toward e0
    typedef struct packed {
        logic v0;
        logic v1;
        tok_t e0;
        tok_t e1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;
    endfunction

    // Keyword lookup: identifier kind when nothing matches
    function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_LEN_W-1:0]     len,
                                                  input logic [8*KW_MAX_LEN-1:0] chars);
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              found;
        kind  = KIND_IDENT;
        found = 1'b0;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if ((i < int'(KW_LEN[k])) &&
                    (chars[8*(KW_MAX_LEN-1-i) +: 8] != KW_TEXT[k][8*(KW_MAX_LEN-1-i) +: 8])) begin
                    hit = 1'b0;
                end
            end
            if (hit && !found) begin
                kind  = KIND_KEYWORD0 + KIND_W'(k);
                found = 1'b1;
            end
        end
        return kind;
    endfunction

endpackage

>>> rtl/sqlx_front.sv
`include "assert_macros.svh"

module sqlx_front #(
    parameter int POS_WIDTH     = sqlx_pkg::POS_WIDTH_DEF,
    parameter int KEYWORD_CHARS = sqlx_pkg::KEYWORD_CHARS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  logic            s_opcode,
    input  logic [7:0]      s_char_code,
    output sqlx_pkg::push_t push
);

    localparam int IDX_W = $clog2(KEYWORD_CHARS);
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_IDENT  = 4'b1000
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] start_reg, start_next;
    logic [POS_WIDTH-1:0] len_reg, len_next;
    logic [7:0]           kw_buf_reg  [KEYWORD_CHARS];
    logic [7:0]           kw_buf_next [KEYWORD_CHARS];

    logic                 accept;
    logic                 close_v;
    logic                 b_v;
    sqlx_pkg::tok_t       close_tok;
    sqlx_pkg::tok_t       b_tok;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    assign accept = s_valid && s_ready;

    // Token that the open mode would close
    always_comb begin
        close_tok          = '0;
        close_tok.start    = sqlx_pkg::OUT_W'(start_reg);
        close_tok.len      = sqlx_pkg::OUT_W'(len_reg);
        close_tok.kw_short = (len_reg <= POS_WIDTH'(sqlx_pkg::KW_MAX_LEN));
        close_tok.kw_len   = len_reg[sqlx_pkg::KW_LEN_W-1:0];
        for (int i = 0; i < sqlx_pkg::KW_MAX_LEN; i++) begin
            close_tok.kw_chars[8*(sqlx_pkg::KW_MAX_LEN-1-i) +: 8] = kw_buf_reg[i];
        end
        case (mode_reg)
            MODE_STRING: close_tok.kind = sqlx_pkg::KIND_STRING;
            MODE_NUMBER: close_tok.kind = sqlx_pkg::KIND_NUMBER;
            default:     close_tok.kind = sqlx_pkg::KIND_IDENT;
        endcase
    end

    // Lexer step for one transfer
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        kw_buf_next = kw_buf_reg;
        close_v     = 1'b0;
        b_v         = 1'b0;
        b_tok       = '0;
        b_tok.start = sqlx_pkg::OUT_W'(pos_reg);
        b_tok.len   = sqlx_pkg::OUT_W'(1);
        b_tok.kind  = sqlx_pkg::KIND_SEMI;

        if (accept) begin
            if (s_opcode == sqlx_pkg::OP_END) begin
                // flush open token, then end of file; back to reset state
                close_v     = (mode_reg != MODE_IDLE);
                b_v         = 1'b1;
                b_tok.kind  = sqlx_pkg::KIND_EOF;
                b_tok.len   = '0;
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                start_next  = '0;
                len_next    = '0;
                for (int i = 0; i < KEYWORD_CHARS; i++) begin
                    kw_buf_next[i] = '0;
                end
            end else begin
                pos_next = sat_inc(pos_reg);
                if (mode_reg == MODE_STRING) begin
                    if (s_char_code == sqlx_pkg::CH_QUOTE) begin
                        close_v   = 1'b1;
                        mode_next = MODE_IDLE;
                    end else begin
                        len_next = sat_inc(len_reg);
                    end
                end else if ((mode_reg == MODE_NUMBER) &&
                             (sqlx_pkg::is_digit(s_char_code) ||
                              (s_char_code == sqlx_pkg::CH_DOT))) begin
                    len_next = sat_inc(len_reg);
                end else if ((mode_reg == MODE_IDENT) &&
                             (sqlx_pkg::is_alpha(s_char_code) ||
                              sqlx_pkg::is_digit(s_char_code) ||
                              (s_char_code == sqlx_pkg::CH_UNDERSCORE))) begin
                    if (len_reg < POS_WIDTH'(KEYWORD_CHARS)) begin
                        kw_buf_next[len_reg[IDX_W-1:0]] = sqlx_pkg::to_upper(s_char_code);
                    end
                    len_next = sat_inc(len_reg);
                end else begin
                    // close whatever is open, then treat the char as in idle
                    close_v   = (mode_reg != MODE_IDLE);
                    mode_next = MODE_IDLE;
                    case (s_char_code)
                        sqlx_pkg::CH_SEMI: begin
                            b_v        = 1'b1;
                            b_tok.kind = sqlx_pkg::KIND_SEMI;
                        end
                        sqlx_pkg::CH_COMMA: begin
                            b_v        = 1'b1;
                            b_tok.kind = sqlx_pkg::KIND_COMMA;
                        end
                        sqlx_pkg::CH_LPAREN: begin
                            b_v        = 1'b1;
                            b_tok.kind = sqlx_pkg::KIND_LPAREN;
                        end
                        sqlx_pkg::CH_RPAREN: begin
                            b_v        = 1'b1;
                            b_tok.kind = sqlx_pkg::KIND_RPAREN;
                        end
                        sqlx_pkg::CH_EQUAL: begin
                            b_v        = 1'b1;
                            b_tok.kind = sqlx_pkg::KIND_EQUAL;
                        end
                        sqlx_pkg::CH_QUOTE: begin
                            mode_next  = MODE_STRING;
                            start_next = pos_reg;
                            len_next   = '0;
                        end
                        default: begin
                            if (sqlx_pkg::is_digit(s_char_code)) begin
                                mode_next  = MODE_NUMBER;
                                start_next = pos_reg;
                                len_next   = POS_WIDTH'(1);
                            end else if (sqlx_pkg::is_alpha(s_char_code) ||
                                         (s_char_code == sqlx_pkg::CH_UNDERSCORE)) begin
                                mode_next      = MODE_IDENT;
                                start_next     = pos_reg;
                                kw_buf_next[0] = sqlx_pkg::to_upper(s_char_code);
                                len_next       = POS_WIDTH'(1);
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Pack results into the queue write, last flag on the final one
    always_comb begin
        push    = '0;
        push.v0 = close_v || b_v;
        push.v1 = close_v && b_v;
        push.e0 = close_v ? close_tok : b_tok;
        push.e1 = b_tok;
        push.e0.last = !(close_v && b_v);
        push.e1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                kw_buf_reg[i] <= '0;
            end
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            kw_buf_reg <= kw_buf_next;
        end
    end

    `SQLX_ASSERT(a_two_needs_open, !push.v1 || (mode_reg != MODE_IDLE), "two tokens from idle mode")

endmodule

>>> rtl/sqlx_queue.sv
`include "assert_macros.svh"

module sqlx_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  sqlx_pkg::push_t push,
    output logic            in_ready,
    output logic            q_valid,
    output sqlx_pkg::tok_t  q_entry,
    input  logic            q_pop
);

    localparam int DEPTH = sqlx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sqlx_pkg::tok_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_push;
    logic             pop;

    // room for a full two-token write
    assign in_ready = (count_reg <= CNT_W'(DEPTH - 2));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    assign pop         = q_pop && q_valid;
    assign n_push      = CNT_W'(push.v0) + CNT_W'(push.v1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + n_push - CNT_W'(pop);

    // slot storage
    always_ff @(posedge aclk) begin
        if (push.v0) begin
            slot_reg[wr_ptr_reg] <= push.e0;
        end
        if (push.v1) begin
            slot_reg[wr_ptr_reg + PTR_W'(1)] <= push.e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SQLX_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count over depth")
    `SQLX_ASSERT(a_push_compact, !push.v1 || push.v0, "second write slot used alone")
    `SQLX_ASSERT(a_push_room, !push.v0 || in_ready, "write into a queue without room")

endmodule

>>> rtl/sqlx_back.sv
`include "assert_macros.svh"

module sqlx_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  sqlx_pkg::tok_t                q_entry,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sqlx_pkg::KIND_W-1:0]   m_token_kind,
    output logic [sqlx_pkg::OUT_W-1:0]    m_start_position,
    output logic [sqlx_pkg::OUT_W-1:0]    m_value_length,
    output logic                          m_last
);

    logic                        m_valid_reg, m_valid_next;
    logic [sqlx_pkg::KIND_W-1:0] kind_reg;
    logic [sqlx_pkg::OUT_W-1:0]  start_reg;
    logic [sqlx_pkg::OUT_W-1:0]  len_reg;
    logic                        last_reg;
    logic [sqlx_pkg::KIND_W-1:0] kind_next;
    logic                        load;

    // output register free or being emptied this cycle
    assign q_pop = !m_valid_reg || m_ready;
    assign load  = q_pop && q_valid;

    // keyword resolution for short identifiers
    always_comb begin
        kind_next = q_entry.kind;
        if ((q_entry.kind == sqlx_pkg::KIND_IDENT) && q_entry.kw_short) begin
            kind_next = sqlx_pkg::kw_kind(q_entry.kw_len, q_entry.kw_chars);
        end
    end

    assign m_valid_next = q_pop ? q_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            start_reg <= q_entry.start;
            len_reg   <= q_entry.len;
            last_reg  <= q_entry.last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_token_kind     = kind_reg;
    assign m_start_position = start_reg;
    assign m_value_length   = len_reg;
    assign m_last           = last_reg;

    `SQLX_ASSERT_NEXT(a_load_shows, load, m_valid_reg, "loaded token not presented")
    `SQLX_ASSERT_NEXT(a_hold_stall, m_valid_reg && !m_ready, m_valid_reg && $stable(kind_reg), "stalled token changed")

endmodule

>>> rtl/sql_token_lexer.sv
// Channel  Handshake         Payload
// s_       s_valid/s_ready   s_opcode, s_char_code (one char or end of text)
// m_       m_valid/m_ready   m_token_kind, m_start_position, m_value_length, m_last
//
// One input transfer per cycle while the four-entry token queue has room for two.
// Each char yields up to two tokens; m_ drains one per cycle while m_ready is high.
// Each token is written into the queue, then loaded into the output register on m_.
// Reset is synchronous on aresetn low and clears lexer state, queue and output valid.
// Stalls on m_ fill the queue; s_ready drops only when fewer than two slots are free.
module sql_token_lexer #(
    parameter int POS_WIDTH     = sqlx_pkg::POS_WIDTH_DEF,
    parameter int KEYWORD_CHARS = sqlx_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [7:0]                  s_char_code,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sqlx_pkg::KIND_W-1:0] m_token_kind,
    output logic [sqlx_pkg::OUT_W-1:0]  m_start_position,
    output logic [sqlx_pkg::OUT_W-1:0]  m_value_length,
    output logic                        m_last
);

    sqlx_pkg::push_t push;
    sqlx_pkg::tok_t  q_entry;
    logic            q_valid;
    logic            q_pop;

    sqlx_front #(
        .POS_WIDTH     (POS_WIDTH),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_char_code (s_char_code),
        .push        (push)
    );

    sqlx_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .in_ready (s_ready),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    sqlx_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_start_position (m_start_position),
        .m_value_length   (m_value_length),
        .m_last           (m_last)
    );

endmodule

>>> test/tb_sql_token_lexer.sv
`timescale 1ns / 1ps

module tb_sql_token_lexer;

    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int ITEM_TARGET   = 1650;
    localparam int KW_BUF_CHARS  = sqlx_pkg::KEYWORD_CHARS_DEF;

    typedef enum logic [3:0] {
        SCAN_IDLE   = 4'b0001,
        SCAN_STRING = 4'b0010,
        SCAN_NUMBER = 4'b0100,
        SCAN_IDENT  = 4'b1000
    } scan_mode_t;

    // One expected token as it should leave the m_ channel
    typedef struct packed {
        logic [sqlx_pkg::KIND_W-1:0] kind;
        logic [sqlx_pkg::OUT_W-1:0]  start;
        logic [sqlx_pkg::OUT_W-1:0]  len;
        logic                        last;
    } token_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_opcode;
    logic [7:0]                  s_char_code;
    logic                        m_valid;
    logic                        m_ready;
    logic [sqlx_pkg::KIND_W-1:0] m_token_kind;
    logic [sqlx_pkg::OUT_W-1:0]  m_start_position;
    logic [sqlx_pkg::OUT_W-1:0]  m_value_length;
    logic                        m_last;

    // Shared between stimulus and result side
    bit     no_idle  = 1'b0;
    bit     hold_off = 1'b0;
    int     errors = 0;
    int     items_sent = 0;
    int     texts_sent = 0;
    int     tokens_checked = 0;
    int     idle_cycles = 0;
    token_t tokens_due[$];

    // Lexer state mirror
    scan_mode_t                 scan_mode;
    logic [sqlx_pkg::OUT_W-1:0] scan_pos;
    logic [sqlx_pkg::OUT_W-1:0] tok_start;
    logic [sqlx_pkg::OUT_W-1:0] tok_len;
    logic [7:0]                 kw_buf [KW_BUF_CHARS];
    int                         emitted_now;

    string kw_names [sqlx_pkg::NUM_KEYWORDS] = '{
        "SELECT", "INSERT", "UPDATE", "DELETE", "CREATE", "DROP", "TABLE", "FROM",
        "WHERE", "INTO", "VALUES", "SET", "AND", "OR", "NOT"
    };
    logic [7:0] punct_chars [5] = '{
        sqlx_pkg::CH_SEMI, sqlx_pkg::CH_COMMA, sqlx_pkg::CH_LPAREN,
        sqlx_pkg::CH_RPAREN, sqlx_pkg::CH_EQUAL
    };

    sql_token_lexer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_char_code      (s_char_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_start_position (m_start_position),
        .m_value_length   (m_value_length),
        .m_last           (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic logic [sqlx_pkg::OUT_W-1:0] bump(input logic [sqlx_pkg::OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bit char_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic bit char_is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic void reset_scan();
        scan_mode = SCAN_IDLE;
        scan_pos  = '0;
        tok_start = '0;
        tok_len   = '0;
        foreach (kw_buf[i]) kw_buf[i] = 8'h00;
    endfunction

    function automatic void expect_token(input logic [sqlx_pkg::KIND_W-1:0] kind,
                                         input logic [sqlx_pkg::OUT_W-1:0]  start,
                                         input logic [sqlx_pkg::OUT_W-1:0]  len);
        token_t t;
        t = '{kind: kind, start: start, len: len, last: 1'b0};
        tokens_due.insert(tokens_due.size(), t);
        emitted_now++;
    endfunction

    // Keyword match only when the length equals the keyword's length
    function automatic logic [sqlx_pkg::KIND_W-1:0] word_kind();
        logic [sqlx_pkg::KIND_W-1:0] kind;
        bit                          same;
        kind = sqlx_pkg::KIND_IDENT;
        for (int k = 0; k < sqlx_pkg::NUM_KEYWORDS; k++) begin
            same = (tok_len == kw_names[k].len());
            if (same) begin
                for (int i = 0; i < kw_names[k].len(); i++) begin
                    if (kw_buf[i] != kw_names[k][i]) same = 1'b0;
                end
            end
            if (same && kind == sqlx_pkg::KIND_IDENT) begin
                kind = sqlx_pkg::KIND_KEYWORD0 + sqlx_pkg::KIND_W'(k);
            end
        end
        return kind;
    endfunction

    function automatic void keep_word_char(input logic [7:0] c);
        if (tok_len < KW_BUF_CHARS) begin
            kw_buf[tok_len[2:0]] = ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;
        end
        tok_len = bump(tok_len);
    endfunction

    function automatic void close_open_token();
        case (scan_mode)
            SCAN_STRING: expect_token(sqlx_pkg::KIND_STRING, tok_start, tok_len);
            SCAN_NUMBER: expect_token(sqlx_pkg::KIND_NUMBER, tok_start, tok_len);
            SCAN_IDENT:  expect_token(word_kind(), tok_start, tok_len);
            default: ;
        endcase
        scan_mode = SCAN_IDLE;
    endfunction

    function automatic void open_token(input scan_mode_t mode);
        scan_mode = mode;
        tok_start = scan_pos;
        tok_len   = '0;
    endfunction

    function automatic void start_from_idle(input logic [7:0] c);
        case (c)
            sqlx_pkg::CH_SEMI:   expect_token(sqlx_pkg::KIND_SEMI, scan_pos, 1);
            sqlx_pkg::CH_COMMA:  expect_token(sqlx_pkg::KIND_COMMA, scan_pos, 1);
            sqlx_pkg::CH_LPAREN: expect_token(sqlx_pkg::KIND_LPAREN, scan_pos, 1);
            sqlx_pkg::CH_RPAREN: expect_token(sqlx_pkg::KIND_RPAREN, scan_pos, 1);
            sqlx_pkg::CH_EQUAL:  expect_token(sqlx_pkg::KIND_EQUAL, scan_pos, 1);
            sqlx_pkg::CH_QUOTE:  open_token(SCAN_STRING);
            default: begin
                if (char_is_digit(c)) begin
                    open_token(SCAN_NUMBER);
                    tok_len = 1;
                end else if (char_is_letter(c) || c == sqlx_pkg::CH_UNDERSCORE) begin
                    open_token(SCAN_IDENT);
                    keep_word_char(c);
                end
                // whitespace and unknown codes fall through
            end
        endcase
    endfunction

    function automatic void lex_predict(input logic op, input logic [7:0] c);
        emitted_now = 0;
        if (op == sqlx_pkg::OP_END) begin
            close_open_token();
            expect_token(sqlx_pkg::KIND_EOF, scan_pos, '0);
            reset_scan();
        end else begin
            if (scan_mode == SCAN_STRING) begin
                if (c == sqlx_pkg::CH_QUOTE) close_open_token();
                else tok_len = bump(tok_len);
            end else if (scan_mode == SCAN_NUMBER &&
                         (char_is_digit(c) || c == sqlx_pkg::CH_DOT)) begin
                tok_len = bump(tok_len);
            end else if (scan_mode == SCAN_IDENT &&
                         (char_is_letter(c) || char_is_digit(c) ||
                          c == sqlx_pkg::CH_UNDERSCORE)) begin
                keep_word_char(c);
            end else begin
                // terminating char is reprocessed from idle
                close_open_token();
                start_from_idle(c);
            end
            scan_pos = bump(scan_pos);
        end
        if (emitted_now > 0) tokens_due[tokens_due.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic offer_char(input logic op, input logic [7:0] code);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_char_code <= code;
        // ready seen mid-cycle decides the transfer at the next edge
        do @(negedge aclk); while (s_ready !== 1'b1);
        @(posedge aclk);
        lex_predict(op, code);
        items_sent++;
        if (op == sqlx_pkg::OP_END) texts_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) offer_char(sqlx_pkg::OP_CHAR, s[i]);
    endtask

    task automatic end_text();
        offer_char(sqlx_pkg::OP_END, 8'($urandom_range(0, 255)));
    endtask

    // Sender pause: let every token come out before going on
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        case ($urandom_range(lead ? 1 : 0, 3))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return 8'h61 + 8'($urandom_range(0, 25));
            default: return sqlx_pkg::CH_UNDERSCORE;
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        return ($urandom_range(0, 3) == 0) ? 8'h09 + 8'($urandom_range(0, 4)) : 8'h20;
    endfunction

    // Statement-like text with random content
    task automatic send_sql_text(input int n_tokens);
        string      word;
        logic [7:0] c;
        int         n;
        for (int t = 0; t < n_tokens; t++) begin
            if ($urandom_range(0, 1) == 1) offer_char(sqlx_pkg::OP_CHAR, pick_space());
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // keyword in mixed case, sometimes clipped or extended
                    word = kw_names[$urandom_range(0, sqlx_pkg::NUM_KEYWORDS-1)];
                    n = word.len();
                    if ($urandom_range(0, 7) == 0) n = n - 1;
                    for (int i = 0; i < n; i++) begin
                        c = word[i];
                        if ($urandom_range(0, 1) == 1) c = c + 8'd32;
                        offer_char(sqlx_pkg::OP_CHAR, c);
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        repeat ($urandom_range(1, 3)) begin
                            offer_char(sqlx_pkg::OP_CHAR, word_char(1'b0));
                        end
                    end
                end
                3, 4: begin
                    n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(6, 12))
                                                    : int'($urandom_range(0, 5));
                    offer_char(sqlx_pkg::OP_CHAR, word_char(1'b1));
                    repeat (n) offer_char(sqlx_pkg::OP_CHAR, word_char(1'b0));
                end
                5: begin
                    offer_char(sqlx_pkg::OP_CHAR, 8'h30 + 8'($urandom_range(0, 9)));
                    repeat ($urandom_range(0, 6)) begin
                        offer_char(sqlx_pkg::OP_CHAR,
                                   ($urandom_range(0, 3) == 0) ? sqlx_pkg::CH_DOT
                                   : 8'h30 + 8'($urandom_range(0, 9)));
                    end
                end
                6: begin
                    offer_char(sqlx_pkg::OP_CHAR, sqlx_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 8)) begin
                        c = 8'($urandom_range(0, 255));
                        if (c == sqlx_pkg::CH_QUOTE) c = 8'h22;
                        offer_char(sqlx_pkg::OP_CHAR, c);
                    end
                    // last string is left open now and then
                    if (t != n_tokens - 1 || $urandom_range(0, 2) != 0)
                        offer_char(sqlx_pkg::OP_CHAR, sqlx_pkg::CH_QUOTE);
                end
                7, 8: offer_char(sqlx_pkg::OP_CHAR, punct_chars[$urandom_range(0, 4)]);
                default: offer_char(sqlx_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
            endcase
        end
        end_text();
    endtask

    // Arbitrary bytes, possibly none, then end of text
    task automatic send_noise_text();
        repeat ($urandom_range(0, 15)) begin
            offer_char(sqlx_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
        end
        end_text();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Keyword then paren in one transfer, ident/number closed by punctuation,
    // string holding extreme codes, skipped high code, unterminated string at end
    task automatic test_directed();
        no_idle = 1'b0;
        send_string("sElECt(_9,8.)=;'");
        offer_char(sqlx_pkg::OP_CHAR, 8'hFF);
        offer_char(sqlx_pkg::OP_CHAR, 8'h00);
        offer_char(sqlx_pkg::OP_CHAR, sqlx_pkg::CH_QUOTE);
        offer_char(sqlx_pkg::OP_CHAR, 8'h20);
        offer_char(sqlx_pkg::OP_CHAR, 8'h80);
        offer_char(sqlx_pkg::OP_CHAR, sqlx_pkg::CH_QUOTE);
        offer_char(sqlx_pkg::OP_CHAR, 8'h78);
        offer_char(sqlx_pkg::OP_END, 8'hFF);
        wait_for_drain();
    endtask

    // Long receiver hold while the sender keeps pushing, so the queue fills
    task automatic test_backpressure();
        no_idle  = 1'b1;
        hold_off = 1'b1;
        send_string("a1;b2;c3;d4;e(f)g=h,i;");
        end_text();
        send_sql_text(30);
        no_idle = 1'b0;
        wait_for_drain();
    endtask

    task automatic test_random_texts();
        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 6) == 0) send_noise_text();
            else send_sql_text($urandom_range(2, 14));
            if ($urandom_range(0, 19) == 0) wait_for_drain();
        end
        no_idle = 1'b0;
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold on request
    // ------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [sqlx_pkg::OUT_W-1:0] want,
                                        input logic [sqlx_pkg::OUT_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    initial begin : result_checker
        token_t want;
        int     stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off = 1'b0;
            end
            stall = no_idle ? 0 : int'($urandom_range(0, 9));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (m_valid !== 1'b1);
            if (tokens_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected token, expected none, actual kind %0d start %0d len %0d",
                         $time, m_token_kind, m_start_position, m_value_length);
            end else begin
                want = tokens_due.pop_front();
                check_field("token_kind", sqlx_pkg::OUT_W'(want.kind),
                            sqlx_pkg::OUT_W'(m_token_kind));
                check_field("start_position", want.start, m_start_position);
                check_field("value_length", want.len, m_value_length);
                check_field("last", sqlx_pkg::OUT_W'(want.last), sqlx_pkg::OUT_W'(m_last));
            end
            tokens_checked++;
            @(posedge aclk);
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = sqlx_pkg::OP_CHAR;
        s_char_code = 8'h00;
        reset_scan();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random_texts();
        wait_for_drain();

        $display("Lexed %0d texts from %0d input transfers; %0d tokens checked, %0d mismatches.",
                 texts_sent, items_sent, tokens_checked, errors);
        $display("Covered punctuation, strings, numbers, identifiers, keywords, noise, stalls.");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sqlx_pkg.sv
rtl/sqlx_front.sv
rtl/sqlx_queue.sv
rtl/sqlx_back.sv
rtl/sql_token_lexer.sv
test/tb_sql_token_lexer.sv
